@@ design/sv32ptw_pkg.sv @@
// Shared types and constants for the Sv32 page-table walker.
// No dependencies; imported by sv32_page_table_walker_unit.
package sv32ptw_pkg;

    localparam int unsigned VA_W    = 32;
    localparam int unsigned PTE_W   = 32;
    localparam int unsigned PPN_W   = 22;
    localparam int unsigned VPN_W   = 10;
    localparam int unsigned PADDR_W = 34;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [4:0] SHIFT_PAGE  = 5'd12;
    localparam logic [4:0] SHIFT_SUPER = 5'd22;

    // Register index, taken from paddr[2].
    localparam logic REG_ROOT_PPN = 1'b0;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ROOT = 2'd1,
        PH_LEAF = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_BUSY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CAUSE_INVALID    = 2'd0,
        CAUSE_NO_LEAF    = 2'd1,
        CAUSE_NO_READ    = 2'd2,
        CAUSE_MISALIGNED = 2'd3
    } cause_t;

endpackage

@@ design/sv32_page_table_walker_unit.sv @@
// A beat accepted on cmd is registered in the input stage, then in the result stage, and is
// presented on res from the result stage, where it can be taken when res is not stalled.
// Throughput: one command beat per cycle while res is not stalled.
// A response beat that arrives while no walk is in progress yields no result beat.
// Reset (rst_n low) returns the walk to idle, clears root_ppn and empties both stages.
// Top level of the Sv32 page-table walker: input stage, walk logic, result stage, APB port.
// Depends on sv32ptw_pkg.
module sv32_page_table_walker_unit
    import sv32ptw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    // Command channel
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  logic                 operation,
    input  logic [VA_W-1:0]      virt_addr,
    input  logic [PTE_W-1:0]     pte_word,
    // Result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [1:0]           result_kind,
    output logic [PADDR_W-1:0]   mem_addr,
    output logic [PPN_W-1:0]     phys_page,
    output logic [4:0]           page_shift,
    output logic [7:0]           pte_flags,
    output logic [1:0]           fault_cause
);

    // Configuration register
    logic [PPN_W-1:0] root_ppn_reg;

    // Input stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_op_reg;
    logic [VA_W-1:0]  s1_va_reg;
    logic [PTE_W-1:0] s1_pte_reg;

    // Walk state
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [VPN_W-1:0] saved_vpn_reg;
    logic [VPN_W-1:0] saved_vpn_next;

    // Result stage
    logic               out_valid_reg;
    logic               out_valid_next;
    kind_t              kind_reg;
    kind_t              kind_next;
    logic [PADDR_W-1:0] addr_reg;
    logic [PADDR_W-1:0] addr_next;
    logic [PPN_W-1:0]   page_reg;
    logic [PPN_W-1:0]   page_next;
    logic [4:0]         shift_reg;
    logic [4:0]         shift_next;
    logic [7:0]         flags_reg;
    logic [7:0]         flags_next;
    cause_t             cause_reg;
    cause_t             cause_next;

    logic cmd_accept;
    logic s2_ready;
    logic s1_fire;
    logic has_result;
    logic busy;
    logic cfg_write;

    logic pte_v;
    logic pte_r;
    logic pte_w;
    logic pte_x;

    // ------------------------------------------------------------------
    // APB port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ROOT_PPN)
        begin
            prdata = {{(APB_DW-PPN_W){1'b0}}, root_ppn_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_ppn_reg <= '0;
        end
        else if (cfg_write && paddr[2] == REG_ROOT_PPN)
        begin
            root_ppn_reg <= pwdata[PPN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s2_ready   = !out_valid_reg || !res_stall;
    assign s1_fire    = s1_valid_reg && s2_ready;
    assign cmd_stall  = s1_valid_reg && !s2_ready;
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_op_reg  <= operation;
            s1_va_reg  <= virt_addr;
            s1_pte_reg <= pte_word;
        end
    end

    // ------------------------------------------------------------------
    // Walk logic
    // ------------------------------------------------------------------
    assign busy  = (phase_reg == PH_ROOT) || (phase_reg == PH_LEAF);
    assign pte_v = s1_pte_reg[0];
    assign pte_r = s1_pte_reg[1];
    assign pte_w = s1_pte_reg[2];
    assign pte_x = s1_pte_reg[3];

    always_comb
    begin
        phase_next     = phase_reg;
        saved_vpn_next = saved_vpn_reg;
        has_result     = 1'b0;
        kind_next      = KIND_READ;
        addr_next      = '0;
        page_next      = '0;
        shift_next     = '0;
        flags_next     = '0;
        cause_next     = CAUSE_INVALID;

        if (s1_fire)
        begin
            case (s1_op_reg)
                OP_TRANSLATE:
                begin
                    has_result = 1'b1;
                    if (busy)
                    begin
                        kind_next = KIND_BUSY;
                    end
                    else
                    begin
                        // The root PPN shifted by 12 leaves room for vpn1 * 4 below it.
                        kind_next      = KIND_READ;
                        addr_next      = {root_ppn_reg, s1_va_reg[31:22], 2'b00};
                        saved_vpn_next = s1_va_reg[21:12];
                        phase_next     = PH_ROOT;
                    end
                end
                OP_RESPONSE:
                begin
                    if (busy)
                    begin
                        has_result = 1'b1;
                        phase_next = PH_IDLE;
                        if (!pte_v || (pte_w && !pte_r))
                        begin
                            kind_next  = KIND_FAULT;
                            cause_next = CAUSE_INVALID;
                        end
                        else if (!pte_r && !pte_w && !pte_x)
                        begin
                            if (phase_reg == PH_ROOT)
                            begin
                                kind_next  = KIND_READ;
                                addr_next  = {s1_pte_reg[31:10], saved_vpn_reg, 2'b00};
                                phase_next = PH_LEAF;
                            end
                            else
                            begin
                                kind_next  = KIND_FAULT;
                                cause_next = CAUSE_NO_LEAF;
                            end
                        end
                        else if (!pte_r)
                        begin
                            kind_next  = KIND_FAULT;
                            cause_next = CAUSE_NO_READ;
                        end
                        else if (phase_reg == PH_ROOT)
                        begin
                            if (s1_pte_reg[19:10] != '0)
                            begin
                                kind_next  = KIND_FAULT;
                                cause_next = CAUSE_MISALIGNED;
                            end
                            else
                            begin
                                kind_next  = KIND_DONE;
                                page_next  = {{(PPN_W-12){1'b0}}, s1_pte_reg[31:20]};
                                shift_next = SHIFT_SUPER;
                                flags_next = s1_pte_reg[7:0];
                            end
                        end
                        else
                        begin
                            kind_next  = KIND_DONE;
                            page_next  = s1_pte_reg[31:10];
                            shift_next = SHIFT_PAGE;
                            flags_next = s1_pte_reg[7:0];
                        end
                    end
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            saved_vpn_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            saved_vpn_reg <= saved_vpn_next;
        end
    end

    // ------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_ready)
        begin
            out_valid_next = s1_fire && has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            page_reg  <= page_next;
            shift_reg <= shift_next;
            flags_reg <= flags_next;
            cause_reg <= cause_next;
        end
    end

    assign res_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign mem_addr    = addr_reg;
    assign phys_page   = page_reg;
    assign page_shift  = shift_reg;
    assign pte_flags   = flags_reg;
    assign fault_cause = cause_reg;

`ifndef NO_ASSERTIONS
    // A second-level read is only ever issued from the root level.
    a_leaf_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEAF) |-> ($past(phase_reg) == PH_ROOT || $past(phase_reg) == PH_LEAF))
        else $error("walk entered second level without a root level");

    // A translate accepted while idle must start a walk.
    a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg == OP_TRANSLATE && phase_reg == PH_IDLE)
            |=> (phase_reg == PH_ROOT))
        else $error("translate while idle did not start a walk");

    // A finished translation carries one of the two page sizes.
    a_done_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_DONE)
            |-> (shift_reg == SHIFT_PAGE || shift_reg == SHIFT_SUPER))
        else $error("translation with bad page shift");

    // Fields that do not belong to the result kind stay zero.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_DONE)
            |-> (page_reg == '0 && flags_reg == '0 && shift_reg == '0))
        else $error("translation fields set on a non-done result");

    // The input stage stalls only behind a full, stalled result stage.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (s1_valid_reg && out_valid_reg && res_stall))
        else $error("command stall without a blocked result");
`endif

endmodule

@@ tb/sv/tb_sv32_page_table_walker_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Sv32 page-table walker: drives walk commands, PTE
// responses and root_ppn writes, and checks every result beat against its own walk model.
// Depends on sv32ptw_pkg and sv32_page_table_walker_unit.
module tb_sv32_page_table_walker_unit
    import sv32ptw_pkg::*;
();

    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 265;

    // Expected walk results, computed from accepted command beats.
    class ptw_scoreboard;
        typedef struct {
            kind_t                kind;
            logic [PADDR_W-1:0]   addr;
            logic [PPN_W-1:0]     page;
            logic [4:0]           shift;
            logic [7:0]           flags;
            cause_t               cause;
        } walk_result_t;

        walk_result_t        pending_results[$];
        logic [PPN_W-1:0]    root_ppn;
        phase_t              phase;
        logic [VPN_W-1:0]    low_vpn;
        int                  errors;

        function new();
            root_ppn = '0;
            phase    = PH_IDLE;
            low_vpn  = '0;
            errors   = 0;
        endfunction

        function void set_root(logic [APB_DW-1:0] value);
            root_ppn = value[PPN_W-1:0];
        endfunction

        function bit walk_busy();
            return (phase == PH_ROOT) || (phase == PH_LEAF);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_command(logic op, logic [VA_W-1:0] va, logic [PTE_W-1:0] pte);
            walk_result_t r;
            bit           at_root;
            r.kind  = KIND_READ;
            r.addr  = '0;
            r.page  = '0;
            r.shift = '0;
            r.flags = '0;
            r.cause = CAUSE_INVALID;
            if (op == OP_TRANSLATE)
            begin
                if (walk_busy())
                begin
                    r.kind = KIND_BUSY;
                end
                else
                begin
                    low_vpn = va[21:12];
                    r.addr  = {root_ppn, 12'h000} + {22'h0, va[31:22], 2'b00};
                    phase   = PH_ROOT;
                end
                pending_results.push_back(r);
                return;
            end
            // A response with no walk in progress is dropped silently.
            if (!walk_busy())
                return;
            at_root = (phase == PH_ROOT);
            phase   = PH_IDLE;
            if (!pte[0] || (pte[2] && !pte[1]))
            begin
                r.kind  = KIND_FAULT;
                r.cause = CAUSE_INVALID;
            end
            else if (pte[3:1] == 3'b000)
            begin
                if (at_root)
                begin
                    phase  = PH_LEAF;
                    r.addr = {pte[31:10], 12'h000} + {22'h0, low_vpn, 2'b00};
                end
                else
                begin
                    r.kind  = KIND_FAULT;
                    r.cause = CAUSE_NO_LEAF;
                end
            end
            else if (!pte[1])
            begin
                r.kind  = KIND_FAULT;
                r.cause = CAUSE_NO_READ;
            end
            else if (at_root && pte[19:10] != '0)
            begin
                r.kind  = KIND_FAULT;
                r.cause = CAUSE_MISALIGNED;
            end
            else
            begin
                r.kind  = KIND_DONE;
                r.flags = pte[7:0];
                if (at_root)
                begin
                    r.page  = {10'h0, pte[31:20]};
                    r.shift = SHIFT_SUPER;
                end
                else
                begin
                    r.page  = pte[31:10];
                    r.shift = SHIFT_PAGE;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void compare(string name, logic [PADDR_W-1:0] exp_v, logic [PADDR_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [PADDR_W-1:0] addr,
                                   logic [PPN_W-1:0] page, logic [4:0] shift,
                                   logic [7:0] flags, logic [1:0] cause);
            walk_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expected result (result_kind %0h)", kind);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            compare("result_kind", PADDR_W'(e.kind), PADDR_W'(kind));
            compare("mem_addr", e.addr, addr);
            compare("phys_page", PADDR_W'(e.page), PADDR_W'(page));
            compare("page_shift", PADDR_W'(e.shift), PADDR_W'(shift));
            compare("pte_flags", PADDR_W'(e.flags), PADDR_W'(flags));
            compare("fault_cause", PADDR_W'(e.cause), PADDR_W'(cause));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 cmd_valid;
    logic                 cmd_stall;
    logic                 operation;
    logic [VA_W-1:0]      virt_addr;
    logic [PTE_W-1:0]     pte_word;
    logic                 res_valid;
    logic                 res_stall;
    logic [1:0]           result_kind;
    logic [PADDR_W-1:0]   mem_addr;
    logic [PPN_W-1:0]     phys_page;
    logic [4:0]           page_shift;
    logic [7:0]           pte_flags;
    logic [1:0]           fault_cause;

    ptw_scoreboard sb;
    bit            quiet = 1'b0;
    int            idle_cycles = 0;
    int            items_sent = 0;

    sv32_page_table_walker_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .operation   (operation),
        .virt_addr   (virt_addr),
        .pte_word    (pte_word),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .result_kind (result_kind),
        .mem_addr    (mem_addr),
        .phys_page   (phys_page),
        .page_shift  (page_shift),
        .pte_flags   (pte_flags),
        .fault_cause (fault_cause)
    );

    always #5 clk = ~clk;

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Builds a PTE of a randomly chosen class; pointers are more common at the root.
    function automatic logic [PTE_W-1:0] make_pte(bit at_root);
        logic [PTE_W-1:0] pte;
        int               sel;
        pte = $urandom;
        sel = $urandom_range(0, 15);
        if (sel == 0)
        begin
            pte[0] = 1'b0;
        end
        else if (sel == 1)
        begin
            pte[2:0] = 3'b101;
        end
        else if (sel == 2)
        begin
            pte[3:0] = 4'b1001;
        end
        else if (sel <= (at_root ? 9 : 4))
        begin
            pte[3:0] = 4'b0001;
        end
        else
        begin
            pte[1:0] = 2'b11;
            if (at_root && chance(50))
                pte[19:10] = '0;
        end
        return pte;
    endfunction

    // Accept monitor: feeds the scoreboard and tracks cycles without progress.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_command(operation, virt_addr, pte_word);
            if (res_valid && !res_stall)
                sb.check_result(result_kind, mem_addr, phys_page, page_shift,
                                pte_flags, fault_cause);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
                (psel && penable && pwrite && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result-side back-pressure in random bursts.
    initial
    begin
        forever
        begin
            if (quiet)
            begin
                res_stall <= 1'b0;
                @(posedge clk);
            end
            else if (chance(30))
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                res_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Drives one command beat and returns at the edge that accepts it, valid still high.
    task automatic send(input logic op, input logic [VA_W-1:0] va,
                        input logic [PTE_W-1:0] pte, input int counts = 1);
        if (!quiet && chance(25))
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        operation <= op;
        virt_addr <= va;
        pte_word  <= pte;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent += counts;
    endtask

    // Lets every outstanding beat drain, then closes any open walk with an invalid PTE.
    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.walk_busy())
        begin
            send(OP_RESPONSE, $urandom, 32'h0);
            cmd_valid <= 1'b0;
            @(posedge clk);
            while (sb.pending() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_root(input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROOT_PPN, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_root(value);
    endtask

    // One well-formed walk with random content, sometimes with busy rejects mixed in.
    task automatic run_walk();
        logic [VA_W-1:0]  va;
        logic [PTE_W-1:0] root_pte;
        va = $urandom;
        if (chance(5))
            va = chance(50) ? '0 : '1;
        send(OP_TRANSLATE, va, $urandom);
        if (chance(15))
            send(OP_TRANSLATE, $urandom, $urandom);
        root_pte = make_pte(1'b1);
        send(OP_RESPONSE, $urandom, root_pte);
        if (root_pte[3:0] == 4'b0001)
        begin
            if (chance(10))
                send(OP_TRANSLATE, $urandom, $urandom);
            send(OP_RESPONSE, $urandom, make_pte(1'b0));
        end
        // A stray response once the walk is over is simply dropped.
        if (chance(8))
            send(OP_RESPONSE, $urandom, $urandom, 0);
    endtask

    initial
    begin
        logic [APB_DW-1:0] root_vals [PHASES];
        sb = new();
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cmd_valid <= 1'b0;
        operation <= OP_TRANSLATE;
        virt_addr <= '0;
        pte_word  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walks on the reset root: full-width addresses and every fault cause.
        send(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0);
        send(OP_RESPONSE, 32'h0, 32'hFFFF_FC01);
        send(OP_RESPONSE, 32'h0, 32'hFFFF_FFFF);
        send(OP_RESPONSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send(OP_TRANSLATE, 32'h0, 32'hFFFF_FFFF);
        send(OP_TRANSLATE, 32'h1234_5678, 32'h0);
        send(OP_RESPONSE, 32'h0, 32'h0);
        send(OP_TRANSLATE, 32'h8040_2000, 32'h0);
        send(OP_RESPONSE, 32'h0, 32'h0000_0005);
        send(OP_TRANSLATE, 32'h0040_1000, 32'h0);
        send(OP_RESPONSE, 32'h0, 32'h0000_0401);
        send(OP_RESPONSE, 32'h0, 32'hFFFF_FC01);
        send(OP_TRANSLATE, 32'hFFC0_0000, 32'h0);
        send(OP_RESPONSE, 32'h0, 32'h0000_0009);
        send(OP_TRANSLATE, 32'h003F_F000, 32'h0);
        send(OP_RESPONSE, 32'h0, 32'h0000_0403);
        send(OP_TRANSLATE, 32'hABCD_E000, 32'h0);
        send(OP_RESPONSE, 32'h0, 32'hFFF0_00CB);
        send(OP_TRANSLATE, 32'h5555_5555, 32'h0);
        send(OP_RESPONSE, 32'h0, 32'h0012_3401);
        send(OP_RESPONSE, 32'h0, 32'h0000_0009);

        root_vals[0] = 32'hFFFF_FFFF;
        root_vals[1] = $urandom;
        root_vals[2] = 32'h0000_0000;
        root_vals[3] = 32'h0000_0001;
        root_vals[4] = $urandom | 32'hFFC0_0000;
        root_vals[5] = 32'h003F_FFFF;
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == PHASES - 1)
                quiet = 1'b1;
            write_root(root_vals[p]);
            while (items_sent < 21 + (p + 1) * PHASE_ITEMS)
            begin
                if (chance(15))
                    send(1'($urandom_range(0, 1)), $urandom, $urandom);
                else
                    run_walk();
            end
        end
        settle();

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
